### src/smf_pkg.sv
package smf_pkg;

    localparam int FRAME_BUFFER_BYTES = 1024;
    localparam int OVERHEAD_BYTES     = 6;
    localparam int ROOM_BYTES         = (FRAME_BUFFER_BYTES > OVERHEAD_BYTES)
                                        ? FRAME_BUFFER_BYTES - OVERHEAD_BYTES : 0;
    localparam int LIMIT_WIDE_INT     = (ROOM_BYTES / 4 > 255) ? 255 : ROOM_BYTES / 4;
    localparam int LIMIT_NARROW_INT   = (ROOM_BYTES / 2 > 255) ? 255 : ROOM_BYTES / 2;
    localparam logic [7:0] LIMIT_WIDE   = LIMIT_WIDE_INT[7:0];
    localparam logic [7:0] LIMIT_NARROW = LIMIT_NARROW_INT[7:0];

    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_WORD  = 1'b1;

    localparam logic [7:0] SYNC0        = 8'hAA;
    localparam logic [7:0] SYNC1        = 8'h55;
    localparam logic [7:0] SYNC2        = 8'hA5;
    localparam logic [7:0] SYNC3_WIDE   = 8'h5A;
    localparam logic [7:0] SYNC3_NARROW = 8'h5B;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TRUNC = 2'd1,
        ST_BUSY  = 2'd2,
        ST_DROP  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_HEADER,
        CMD_WORD,
        CMD_REJECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        status_t     status;
        logic        wide;
        logic        closes;
        logic [7:0]  count;
        logic [31:0] data;
    } cmd_t;

endpackage

### src/smf_if.sv
interface smf_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [15:0]        word_count;
    logic               wide;
    logic signed [31:0] data_word;

    modport source (output valid, op, word_count, wide, data_word, input ready);
    modport sink (input valid, op, word_count, wide, data_word, output ready);
endinterface

interface smf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       byte_valid;
    logic       frame_end;
    logic       last;
    logic [1:0] status;

    modport source (output valid, tx_byte, byte_valid, frame_end, last, status, input ready);
    modport sink (input valid, tx_byte, byte_valid, frame_end, last, status, output ready);
endinterface

### src/smf_front.sv
module smf_front #(
    parameter int FRAME_BUFFER_BYTES = smf_pkg::FRAME_BUFFER_BYTES
) (
    input  logic         clk,
    input  logic         rst_n,
    smf_in_if.sink       in_ch,
    input  logic         q_full,
    output logic         push,
    output smf_pkg::cmd_t push_cmd
);
    import smf_pkg::*;

    localparam int FRAME_ROOM       = (FRAME_BUFFER_BYTES > OVERHEAD_BYTES)
                                      ? FRAME_BUFFER_BYTES - OVERHEAD_BYTES : 0;
    localparam int WIDE_LIMIT_INT   = (FRAME_ROOM / 4 > 255) ? 255 : FRAME_ROOM / 4;
    localparam int NARROW_LIMIT_INT = (FRAME_ROOM / 2 > 255) ? 255 : FRAME_ROOM / 2;
    localparam logic [7:0] WIDE_LIMIT   = WIDE_LIMIT_INT[7:0];
    localparam logic [7:0] NARROW_LIMIT = NARROW_LIMIT_INT[7:0];

    logic       open_reg, open_next;
    logic       wide_reg, wide_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] limit;
    logic [7:0] count;
    logic       trunc;

    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    always_comb
    begin
        limit = in_ch.wide ? WIDE_LIMIT : NARROW_LIMIT;
        trunc = in_ch.word_count > {8'd0, limit};
        count = trunc ? limit : in_ch.word_count[7:0];

        open_next = open_reg;
        wide_next = wide_reg;
        left_next = left_reg;

        push_cmd.kind   = CMD_REJECT;
        push_cmd.status = ST_OK;
        push_cmd.wide   = wide_reg;
        push_cmd.closes = 1'b0;
        push_cmd.count  = count;
        push_cmd.data   = in_ch.data_word;

        if (in_ch.op == OP_START)
        begin
            if (open_reg)
            begin
                push_cmd.status = ST_BUSY;
            end
            else
            begin
                push_cmd.kind   = CMD_HEADER;
                push_cmd.status = trunc ? ST_TRUNC : ST_OK;
                push_cmd.wide   = in_ch.wide;
                open_next       = count != 8'd0;
                wide_next       = in_ch.wide;
                left_next       = count;
            end
        end
        else
        begin
            if (!open_reg)
            begin
                push_cmd.status = ST_DROP;
            end
            else
            begin
                push_cmd.kind   = CMD_WORD;
                push_cmd.closes = left_reg <= 8'd1;
                left_next       = left_reg - 8'd1;
                if (left_reg <= 8'd1)
                begin
                    open_next = 1'b0;
                    left_next = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            wide_reg <= 1'b0;
            left_reg <= 8'd0;
        end
        else if (push)
        begin
            open_reg <= open_next;
            wide_reg <= wide_next;
            left_reg <= left_next;
        end
    end

endmodule

### src/smf_queue.sv
module smf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  smf_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output smf_pkg::cmd_t head,
    output logic          empty
);
    import smf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full  = cnt_reg == DEPTH_CNT;
    assign empty = cnt_reg == '0;
    assign head  = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == LAST_PTR) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == LAST_PTR) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### src/smf_back.sv
module smf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  smf_pkg::cmd_t head,
    input  logic          empty,
    output logic          pop,
    smf_out_if.source     out_ch
);
    import smf_pkg::*;

    logic       ovalid_reg;
    logic [7:0] byte_reg, byte_next;
    logic       bvalid_reg, bvalid_next;
    logic       fend_reg, fend_next;
    logic       last_reg, last_next;
    logic [1:0] status_reg;
    logic [2:0] idx_reg;
    logic [7:0] sum_reg, sum_next;
    logic [2:0] nbytes;
    logic [7:0] word_byte;
    logic       load;
    logic       done;

    assign out_ch.valid      = ovalid_reg;
    assign out_ch.tx_byte    = byte_reg;
    assign out_ch.byte_valid = bvalid_reg;
    assign out_ch.frame_end  = fend_reg;
    assign out_ch.last       = last_reg;
    assign out_ch.status     = status_reg;

    assign load = !empty && (!ovalid_reg || out_ch.ready);
    assign pop  = load && done;

    always_comb
    begin
        nbytes      = head.wide ? 3'd4 : 3'd2;
        word_byte   = head.data[{idx_reg[1:0], 3'b000} +: 8];
        byte_next   = 8'd0;
        bvalid_next = 1'b1;
        fend_next   = 1'b0;
        last_next   = 1'b0;
        sum_next    = sum_reg;
        done        = 1'b0;

        unique case (head.kind)
            CMD_HEADER:
            begin
                unique case (idx_reg)
                    3'd0: byte_next = SYNC0;
                    3'd1: byte_next = SYNC1;
                    3'd2: byte_next = SYNC2;
                    3'd3: byte_next = head.wide ? SYNC3_WIDE : SYNC3_NARROW;
                    3'd4:
                    begin
                        byte_next = head.count;
                        sum_next  = head.count;
                        last_next = head.count != 8'd0;
                        done      = head.count != 8'd0;
                    end
                    default:
                    begin
                        byte_next = sum_reg;
                        fend_next = 1'b1;
                        last_next = 1'b1;
                        done      = 1'b1;
                    end
                endcase
            end
            CMD_WORD:
            begin
                if (idx_reg < nbytes)
                begin
                    byte_next = word_byte;
                    sum_next  = sum_reg + word_byte;
                    if (idx_reg == nbytes - 3'd1 && !head.closes)
                    begin
                        last_next = 1'b1;
                        done      = 1'b1;
                    end
                end
                else
                begin
                    byte_next = sum_reg;
                    fend_next = 1'b1;
                    last_next = 1'b1;
                    done      = 1'b1;
                end
            end
            default:
            begin
                bvalid_next = 1'b0;
                last_next   = 1'b1;
                done        = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= byte_next;
            bvalid_reg <= bvalid_next;
            fend_reg   <= fend_next;
            last_reg   <= last_next;
            status_reg <= head.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            idx_reg    <= 3'd0;
            sum_reg    <= 8'd0;
        end
        else
        begin
            if (load)
            begin
                ovalid_reg <= 1'b1;
                sum_reg    <= sum_next;
                idx_reg    <= done ? 3'd0 : idx_reg + 3'd1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

endmodule

### src/sync_marker_integer_framer.sv
// Frames 16- or 32-bit integers for a serial link, one byte per transfer on out_ch.
// A start transfer yields the sync marker AA 55 A5 5A (32-bit) or AA 55 A5 5B (16-bit)
// and a count byte clamped to the buffer limit (five bytes, six with the checksum when
// the count is zero); a word transfer yields 2 or 4 bytes little-endian, plus the
// checksum byte after the last counted word. Rejected starts and dropped words give
// one transfer with byte_valid low. Output pace is one byte per cycle while out_ch.ready
// holds, so an item occupies the serializer for 1 to 6 bytes (4 for a 32-bit word, 5
// when it also carries the checksum); a two-entry command queue lets input transfers be
// taken while bytes drain, until the queue is full.
module sync_marker_integer_framer #(
    parameter int FRAME_BUFFER_BYTES = smf_pkg::FRAME_BUFFER_BYTES
) (
    input  logic      clk,
    input  logic      rst_n,
    smf_in_if.sink    in_ch,
    smf_out_if.source out_ch
);
    import smf_pkg::*;

    cmd_t push_cmd;
    cmd_t head;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    smf_front #(
        .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    smf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    smf_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (q_empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

### verif/smf_frame_monitor.sv
`timescale 1ns / 100ps

module smf_frame_monitor (
    input  logic clk,
    input  logic rst_n,
    smf_in_if    in_ch,
    smf_out_if   out_ch,
    output int   pending,
    output int   fail_count,
    output int   bytes_checked,
    output int   frames_closed,
    output int   flagged_count
);
    import smf_pkg::*;

    typedef struct {
        logic [7:0] tx_byte;
        logic       byte_valid;
        logic       frame_end;
        logic       last;
        status_t    status;
    } link_byte_t;

    link_byte_t expected_bytes[$];

    // framer state as the predictor sees it
    logic       is_open   = 1'b0;
    logic       open_wide = 1'b0;
    logic [7:0] words_due = '0;
    logic [7:0] csum      = '0;

    int errs     = 0;
    int bytes_n  = 0;
    int frames_n = 0;
    int flagged  = 0;

    function automatic void push_result(input logic [7:0] b, input logic vld, input logic fend,
                                        input logic lst, input status_t st);
        link_byte_t r;
        r.tx_byte    = b;
        r.byte_valid = vld;
        r.frame_end  = fend;
        r.last       = lst;
        r.status     = st;
        expected_bytes.push_back(r);
    endfunction

    function automatic int field_diff(input string field, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", field, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    task automatic predict_transfer(input logic op, input logic [15:0] req, input logic w,
                                    input logic [31:0] word);
        int         limit_words;
        logic [7:0] cnt;
        status_t    st;
        int         nbytes;
        logic       closes;
        logic [7:0] b;
        if (op == OP_START)
        begin
            if (is_open)
                push_result(8'h00, 1'b0, 1'b0, 1'b1, ST_BUSY);
            else
            begin
                limit_words = (FRAME_BUFFER_BYTES > OVERHEAD_BYTES)
                              ? FRAME_BUFFER_BYTES - OVERHEAD_BYTES : 0;
                limit_words = limit_words / (w ? 4 : 2);
                if (limit_words > 255)
                    limit_words = 255;
                st  = ST_OK;
                cnt = req[7:0];
                if (int'(req) > limit_words)
                begin
                    cnt = limit_words[7:0];
                    st  = ST_TRUNC;
                end
                open_wide = w;
                words_due = cnt;
                csum      = cnt;
                is_open   = (cnt != 8'd0);
                push_result(SYNC0, 1'b1, 1'b0, 1'b0, st);
                push_result(SYNC1, 1'b1, 1'b0, 1'b0, st);
                push_result(SYNC2, 1'b1, 1'b0, 1'b0, st);
                push_result(w ? SYNC3_WIDE : SYNC3_NARROW, 1'b1, 1'b0, 1'b0, st);
                push_result(cnt, 1'b1, 1'b0, cnt != 8'd0, st);
                if (cnt == 8'd0)
                    push_result(csum, 1'b1, 1'b1, 1'b1, st);
            end
        end
        else if (!is_open)
            push_result(8'h00, 1'b0, 1'b0, 1'b1, ST_DROP);
        else
        begin
            nbytes = open_wide ? 4 : 2;
            closes = (words_due <= 8'd1);
            for (int i = 0; i < nbytes; i++)
            begin
                b    = word[8*i +: 8];
                csum = csum + b;
                push_result(b, 1'b1, 1'b0, !closes && (i == nbytes - 1), ST_OK);
            end
            words_due = words_due - 8'd1;
            if (closes)
            begin
                push_result(csum, 1'b1, 1'b1, 1'b1, ST_OK);
                is_open   = 1'b0;
                words_due = '0;
            end
        end
    endtask

    always @(posedge clk)
    begin
        link_byte_t want;
        if (!rst_n)
        begin
            is_open   = 1'b0;
            open_wide = 1'b0;
            words_due = '0;
            csum      = '0;
            expected_bytes.delete();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_transfer(in_ch.op, in_ch.word_count, in_ch.wide, in_ch.data_word);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("output transfer with nothing expected: tx_byte %0h status %0d",
                           out_ch.tx_byte, out_ch.status);
                    errs++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    errs += field_diff("tx_byte", 32'(want.tx_byte), 32'(out_ch.tx_byte));
                    errs += field_diff("byte_valid", 32'(want.byte_valid),
                                       32'(out_ch.byte_valid));
                    errs += field_diff("frame_end", 32'(want.frame_end),
                                       32'(out_ch.frame_end));
                    errs += field_diff("last", 32'(want.last), 32'(out_ch.last));
                    errs += field_diff("status", 32'(want.status), 32'(out_ch.status));
                    if (want.byte_valid)
                        bytes_n++;
                    if (want.frame_end)
                        frames_n++;
                    if (want.status == ST_BUSY || want.status == ST_DROP)
                        flagged++;
                end
            end
        end
        pending       <= expected_bytes.size();
        fail_count    <= errs;
        bytes_checked <= bytes_n;
        frames_closed <= frames_n;
        flagged_count <= flagged;
    end

endmodule

### verif/sync_marker_integer_framer_tb.sv
`timescale 1ns / 100ps

module sync_marker_integer_framer_tb;
    import smf_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 24;

    logic clk;
    logic rst_n;

    smf_in_if  in_ch ();
    smf_out_if out_ch ();

    int pending;
    int fail_count;
    int bytes_checked;
    int frames_closed;
    int flagged_count;

    int  cycles      = 0;
    int  items_sent  = 0;
    int  starts_sent = 0;
    bit  steady_in   = 1'b0;

    sync_marker_integer_framer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    smf_frame_monitor u_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .pending       (pending),
        .fail_count    (fail_count),
        .bytes_checked (bytes_checked),
        .frames_closed (frames_closed),
        .flagged_count (flagged_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    initial
    begin
        int hold;
        int run;
        out_ch.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                run = $urandom_range(40, 150);
            else
            begin
                hold = idle_length();
                if (hold > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (hold) @(posedge clk);
                end
                run = $urandom_range(1, 6);
            end
            out_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
        end
    end

    task automatic send_item(input logic op_i, input logic [15:0] cnt_i, input logic wide_i,
                             input logic [31:0] data_i);
        int gap;
        gap = steady_in ? 0 : idle_length();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op_i;
        in_ch.word_count <= cnt_i;
        in_ch.wide       <= wide_i;
        in_ch.data_word  <= data_i;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        if (op_i == OP_START)
            starts_sent++;
    endtask

    task automatic send_word(input logic [31:0] data_i);
        send_item(OP_WORD, 16'($urandom), 1'($urandom_range(0, 1)), data_i);
    endtask

    // start, the counted words with stray busy starts mixed in, then maybe surplus words
    task automatic random_frame();
        logic        w;
        logic [15:0] req;
        int          lim;
        int          due;
        int          extra;
        w         = 1'($urandom_range(0, 1));
        steady_in = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0)
            req = 16'($urandom_range(7, 40));
        else
            req = 16'($urandom_range(0, 6));
        lim = int'(w ? LIMIT_WIDE : LIMIT_NARROW);
        due = (int'(req) > lim) ? lim : int'(req);
        send_item(OP_START, req, w, $urandom);
        for (int i = 0; i < due; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(OP_START, 16'($urandom), 1'($urandom_range(0, 1)), $urandom);
            send_word($urandom);
        end
        extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
        repeat (extra) send_word($urandom);
    endtask

    initial
    begin
        int first_random;
        int frame_idx;
        in_ch.valid      = 1'b0;
        in_ch.op         = OP_START;
        in_ch.word_count = '0;
        in_ch.wide       = 1'b0;
        in_ch.data_word  = '0;
        rst_n            = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // words with no frame open
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0000);
        // zero-count frames, both widths
        send_item(OP_START, 16'h0000, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_START, 16'h0000, 1'b0, 32'h0000_0000);
        // narrow frame, busy start inside, surplus word after
        send_item(OP_START, 16'd2, 1'b0, 32'h0000_0000);
        send_item(OP_START, 16'd3, 1'b1, 32'h1234_5678);
        send_word(32'h1234_FFFF);
        send_word(32'hFFFF_0001);
        send_word(32'hDEAD_BEEF);
        // wide frames with extreme words
        send_item(OP_START, 16'd1, 1'b1, 32'h0000_0000);
        send_word(32'h8000_0000);
        send_item(OP_START, 16'd2, 1'b1, 32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);
        // truncated count, filled to the clamped limit
        send_item(OP_START, 16'hFFFF, 1'b1, 32'h0000_0000);
        send_item(OP_START, 16'h0010, 1'b0, 32'h0000_0000);
        send_word(32'h7FFF_FFFF);
        for (int i = 1; i < LIMIT_WIDE; i++)
            send_word($urandom);
        send_word(32'h0000_0001);

        first_random = items_sent;
        frame_idx    = 0;
        while (items_sent - first_random < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 6) == 0)
                send_word($urandom);
            random_frame();
            frame_idx++;
        end

        // narrow truncated count, frame left open at the end
        steady_in = 1'b0;
        send_item(OP_START, 16'd300, 1'b0, 32'h0000_0000);
        send_word(32'h8000_7FFF);
        send_word(32'h0000_8000);
        in_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (pending != 0)
            $error("%0d expected output transfers never arrived", pending);
        $display("%0d input transfers (%0d starts, %0d frames in the random part) sent",
                 items_sent, starts_sent, frame_idx);
        $display("%0d link bytes checked, %0d frames closed, %0d busy or dropped results",
                 bytes_checked, frames_closed, flagged_count);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sync_marker_integer_framer.f
src/smf_pkg.sv
src/smf_if.sv
src/smf_front.sv
src/smf_queue.sv
src/smf_back.sv
src/sync_marker_integer_framer.sv
verif/smf_frame_monitor.sv
verif/sync_marker_integer_framer_tb.sv
